[hw/rtl/he_pkg.sv]
// Shared types and constants of the histogram equalizer.
// Used by he_div and histogram_equalizer under hw/rtl; depends on nothing else.
package he_pkg;

   // Fixed field widths.
   localparam int PIX_W     = 8;   // grey level of an input word
   localparam int LEVEL_W   = 8;   // equalized level of a result word
   localparam int BIN_W     = 24;  // one histogram bin
   localparam int CFG_W     = 13;  // size registers
   localparam int CSR_IDX_W = 2;   // register index on the configuration port

   localparam logic [BIN_W-1:0] BIN_MAX = {BIN_W{1'b1}};

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;

   localparam logic [CFG_W-1:0] SIDE_RESET = 13'd512;

   // Input word kinds carried on tuser.
   localparam logic MODE_COUNT = 1'b0;
   localparam logic MODE_MAP   = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CNT_WR,
      ST_MAP_OUT,
      ST_BLD_RD,
      ST_BLD_MUL,
      ST_BLD_ACC,
      ST_BLD_GO,
      ST_BLD_DIV
   } st_type;

   // Status of the shared divider as seen by the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
      logic ovf;
   } div_stat_type;

endpackage

[hw/rtl/he_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; holds no reset.
module he_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/he_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
// Depends on he_pkg for the status struct.
module he_div #(
   parameter int NUM_W = 40,
   parameter int DEN_W = 26,
   parameter int QUO_W = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NUM_W-1:0]    num,
   input  logic [DEN_W-1:0]    den,
   output logic [QUO_W-1:0]    quo,
   output he_pkg::div_stat_type stat
);

   localparam int SH_W  = DEN_W + QUO_W;
   localparam int CMP_W = ((NUM_W > SH_W) ? NUM_W : SH_W) + 1;
   localparam int CNT_W = $clog2(QUO_W + 1);

   logic [NUM_W-1:0] rem_ff, rem_in;
   logic [SH_W-1:0]  dsh_ff, dsh_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic             ovf_ff, ovf_in;
   logic             fits;

   // The shared compare and subtract step.
   assign fits = CMP_W'(rem_ff) >= CMP_W'(dsh_ff);

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      ovf_in  = ovf_ff;
      if (start) begin
         rem_in  = num;
         dsh_in  = SH_W'(den) << (QUO_W - 1);
         quo_in  = '0;
         cnt_in  = CNT_W'(QUO_W);
         busy_in = 1'b1;
         ovf_in  = CMP_W'(num) >= (CMP_W'(den) << QUO_W);
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - NUM_W'(dsh_ff);
         end
         quo_in = {quo_ff[QUO_W-2:0], fits};
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
      ovf_ff <= ovf_in;
   end

   assign quo       = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign stat.ovf  = ovf_ff;

endmodule

[hw/rtl/histogram_equalizer.sv]
// Top level of the two-pass grey-level histogram equalizer.
// Depends on he_pkg, he_ram (histogram and level map) and he_div (shared divider).
//
// Pixels arrive as words on the req_ channel with tuser selecting the pass: a count word
// adds one to the pixel's histogram bin (bins saturate at 2^24-1) and produces nothing,
// a map word returns the pixel's equalized level on the rsp_ channel. A count word with
// tlast set is counted and then starts the map build: for every level j the cumulative
// count up to j, times GREY_LEVELS-1, is divided by width times height and floored,
// saturating at GREY_LEVELS-1; the bins are cleared in the same sweep. Width and height
// are clamped to 1..MAX_SIDE. Pixels at or above GREY_LEVELS are not counted and map to 0.
// Flow: a count word or a map word is accepted, then goes to the RAM read-modify-write or
// the map read; the map read waits while the output register holds an untaken result, and
// a finished result may wait there while the next word is taken. The map build occupies
// the block while every level in turn is read, multiplied, accumulated and passed through
// the bit-per-cycle divider. After reset a clearing pass over all GREY_LEVELS addresses
// zeroes both RAMs before the first word is taken; configuration writes are taken at any
// time.
module histogram_equalizer #(
   parameter int GREY_LEVELS = 256,
   parameter int MAX_SIDE    = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   // Input pixels.
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [he_pkg::PIX_W-1:0]      req_tdata,   // [7:0] pixel
   input  logic                          req_tuser,   // [0] mode
   input  logic                          req_tlast,
   // Equalized levels.
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [he_pkg::LEVEL_W-1:0]    rsp_tdata,   // [7:0] level
   // Register writes.
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [he_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [he_pkg::CFG_W-1:0]      csr_data
);

   localparam int LVL_W  = $clog2(GREY_LEVELS);
   localparam int SIDE_W = $clog2(MAX_SIDE + 1);
   localparam int TOT_W  = 2 * SIDE_W;
   localparam int CUM_W  = he_pkg::BIN_W + LVL_W;
   localparam int NUM_W  = CUM_W + LVL_W;
   localparam int PIX_W  = he_pkg::PIX_W;
   localparam int BIN_W  = he_pkg::BIN_W;
   localparam int CFG_W  = he_pkg::CFG_W;
   localparam logic [LVL_W-1:0] TOP      = LVL_W'(GREY_LEVELS - 1);
   localparam logic [LVL_W-1:0] LAST_IDX = LVL_W'(GREY_LEVELS - 1);

   // A side register of zero counts as one, any value above MAX_SIDE as MAX_SIDE.
   function automatic logic [SIDE_W-1:0] clamp_side(input logic [CFG_W-1:0] v);
      logic [SIDE_W-1:0] r;
      if (v == '0) begin
         r = SIDE_W'(1);
      end else if (32'(v) > 32'(MAX_SIDE)) begin
         r = SIDE_W'(MAX_SIDE);
      end else begin
         r = SIDE_W'(v);
      end
      return r;
   endfunction

   he_pkg::st_type state_ff, state_in;

   logic [LVL_W-1:0]  addr_ff, addr_in;
   logic              last_ff, last_in;
   logic              pix_ok_ff, pix_ok_in;
   logic [TOT_W-1:0]  total_ff, total_in;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [CUM_W-1:0]  prod_ff, prod_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [he_pkg::LEVEL_W-1:0] level_ff, level_in;
   logic [CFG_W-1:0]  width_ff, width_in;
   logic [CFG_W-1:0]  height_ff, height_in;

   logic [LVL_W-1:0]  rd_addr;
   logic [LVL_W-1:0]  req_idx;
   logic [LVL_W+PIX_W-1:0] req_ext;
   logic [LVL_W+7:0]  map_ext;
   logic              bin_we;
   logic [BIN_W-1:0]  bin_wd;
   logic [BIN_W-1:0]  bin_rd;
   logic              map_we;
   logic [LVL_W-1:0]  map_wd;
   logic [LVL_W-1:0]  map_rd;
   logic              div_start;
   logic [LVL_W-1:0]  div_quo;
   logic [LVL_W-1:0]  div_level;
   he_pkg::div_stat_type div_stat;

   // The pixel picks a bin through its low bits; words beyond the bins are flagged.
   assign req_ext = {LVL_W'(0), req_tdata};
   assign req_idx = req_ext[LVL_W-1:0];
   assign map_ext = {8'd0, map_rd};

   // Quotient saturated to the top level.
   assign div_level = (div_stat.ovf || div_quo > TOP) ? TOP : div_quo;

   // Both RAMs read the pixel straight from the port while idle, the held address otherwise.
   assign rd_addr = (state_ff == he_pkg::ST_IDLE) ? req_idx : addr_ff;

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      last_in      = last_ff;
      pix_ok_in    = pix_ok_ff;
      total_in     = total_ff;
      num_in       = num_ff;
      prod_in      = prod_ff;
      level_in     = level_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      width_in     = width_ff;
      height_in    = height_ff;
      bin_we       = 1'b0;
      bin_wd       = '0;
      map_we       = 1'b0;
      map_wd       = '0;
      div_start    = 1'b0;

      if (csr_valid) begin
         if (csr_index == he_pkg::CSR_IMAGE_WIDTH) begin
            width_in = csr_data;
         end
         if (csr_index == he_pkg::CSR_IMAGE_HEIGHT) begin
            height_in = csr_data;
         end
      end

      case (state_ff)
         he_pkg::ST_CLEAR: begin
            bin_we = 1'b1;
            map_we = 1'b1;
            if (addr_ff == LAST_IDX) begin
               addr_in  = '0;
               state_in = he_pkg::ST_IDLE;
            end else begin
               addr_in = addr_ff + LVL_W'(1);
            end
         end
         he_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               addr_in   = req_idx;
               last_in   = req_tlast;
               pix_ok_in = 32'(req_tdata) < 32'(GREY_LEVELS);
               state_in  = (req_tuser == he_pkg::MODE_MAP) ? he_pkg::ST_MAP_OUT
                                                          : he_pkg::ST_CNT_WR;
            end
         end
         he_pkg::ST_CNT_WR: begin
            bin_we = pix_ok_ff && (bin_rd != he_pkg::BIN_MAX);
            bin_wd = bin_rd + BIN_W'(1);
            if (last_ff) begin
               total_in = TOT_W'(clamp_side(width_ff)) * TOT_W'(clamp_side(height_ff));
               num_in   = '0;
               addr_in  = '0;
               state_in = he_pkg::ST_BLD_RD;
            end else begin
               state_in = he_pkg::ST_IDLE;
            end
         end
         he_pkg::ST_MAP_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               level_in     = pix_ok_ff ? map_ext[7:0] : '0;
               state_in     = he_pkg::ST_IDLE;
            end
         end
         he_pkg::ST_BLD_RD: begin
            state_in = he_pkg::ST_BLD_MUL;
         end
         he_pkg::ST_BLD_MUL: begin
            prod_in  = CUM_W'(bin_rd) * CUM_W'(TOP);
            bin_we   = 1'b1;
            state_in = he_pkg::ST_BLD_ACC;
         end
         he_pkg::ST_BLD_ACC: begin
            num_in   = num_ff + NUM_W'(prod_ff);
            state_in = he_pkg::ST_BLD_GO;
         end
         he_pkg::ST_BLD_GO: begin
            div_start = 1'b1;
            state_in  = he_pkg::ST_BLD_DIV;
         end
         he_pkg::ST_BLD_DIV: begin
            if (div_stat.done) begin
               map_we = 1'b1;
               map_wd = div_level;
               if (addr_ff == LAST_IDX) begin
                  state_in = he_pkg::ST_IDLE;
               end else begin
                  addr_in  = addr_ff + LVL_W'(1);
                  state_in = he_pkg::ST_BLD_RD;
               end
            end
         end
         default: begin
            state_in = he_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= he_pkg::ST_CLEAR;
         addr_ff      <= '0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         width_ff     <= he_pkg::SIDE_RESET;
         height_ff    <= he_pkg::SIDE_RESET;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
      end
      pix_ok_ff <= pix_ok_in;
      total_ff  <= total_in;
      num_ff    <= num_in;
      prod_ff   <= prod_in;
      level_ff  <= level_in;
   end

   // Histogram bins.
   he_ram #(
      .WIDTH (BIN_W),
      .DEPTH (GREY_LEVELS)
   ) u_bins (
      .clock   (clock),
      .wr_en   (bin_we),
      .wr_addr (addr_ff),
      .wr_data (bin_wd),
      .rd_addr (rd_addr),
      .rd_data (bin_rd)
   );

   // Level map.
   he_ram #(
      .WIDTH (LVL_W),
      .DEPTH (GREY_LEVELS)
   ) u_map (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (addr_ff),
      .wr_data (map_wd),
      .rd_addr (rd_addr),
      .rd_data (map_rd)
   );

   // Shared divider for the scaled cumulative counts.
   he_div #(
      .NUM_W (NUM_W),
      .DEN_W (TOT_W),
      .QUO_W (LVL_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_ff),
      .den   (total_ff),
      .quo   (div_quo),
      .stat  (div_stat)
   );

   assign req_tready = (state_ff == he_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = level_ff;
   assign csr_ready  = 1'b1;

`ifndef SYNTHESIS
   // The divider only runs while the sequencer waits for it.
   a_div_owned: assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> state_ff == he_pkg::ST_BLD_DIV)
      else $error("divider busy outside the build wait");

   // No map entry is ever written above the top level.
   a_map_range: assert property (@(posedge clock) disable iff (reset)
      map_we |-> map_wd <= TOP)
      else $error("level map written out of range");

   // A new result only appears after a map read.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == he_pkg::ST_MAP_OUT)
      else $error("result raised without a map read");

   // The build sweep ends after the last level and hands back to idle.
   a_build_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == he_pkg::ST_BLD_DIV && div_stat.done && addr_ff == LAST_IDX)
      |=> state_ff == he_pkg::ST_IDLE)
      else $error("build sweep did not finish at the last level");
`endif

endmodule
